### src/lrpg_pkg.sv
// ----------------------------------------------------------------------------
// LED ring pattern generator package
// Item codes, pattern codes and timing constants shared by the block.
// ----------------------------------------------------------------------------
package lrpg_pkg;

   // Item kinds carried on the request tuser
   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_SET  = 2'd1,
      OP_PLAY = 2'd2
   } op_type;

   typedef logic [3:0]  pattern_type;
   typedef logic [13:0] ms_type;
   typedef logic [6:0]  ticks_type;
   typedef logic [7:0]  level_type;

   // Pattern codes
   localparam pattern_type PAT_OFF          = 4'd0;
   localparam pattern_type PAT_WHITE        = 4'd1;
   localparam pattern_type PAT_BREATHE      = 4'd2;
   localparam pattern_type PAT_AMBER_SLOW   = 4'd3;
   localparam pattern_type PAT_AMBER_RAPID  = 4'd4;
   localparam pattern_type PAT_GREEN        = 4'd5;
   localparam pattern_type PAT_BLUE_PULSE   = 4'd6;
   localparam pattern_type PAT_RED_TRIPLE   = 4'd7;
   localparam pattern_type PAT_SOLID_RED    = 4'd8;

   // Time base: common period of all patterns
   localparam int TIME_WRAP = 12000;
   localparam int COUNT_MAX = 127;

   // Play durations in milliseconds
   localparam int PLAY_MS_AMBER_SLOW = 3000;
   localparam int PLAY_MS_GREEN      = 700;
   localparam int PLAY_MS_RED_TRIPLE = 900;
   localparam int PLAY_MS_DEFAULT    = 500;

   // Reciprocal multipliers, exact over the ranges used
   // floor(ms/120)  = (ms * Q120_MUL) >> 22, ms < 12000
   // floor(ms/150)  = (ms * Q150_MUL) >> 22, ms < 12000
   // floor(u*12/2000) = (u * BREATHE_MUL) >> 24, u <= 2000
   // floor(u*50/1000) = (u * PULSE_MUL) >> 16, u <= 1000
   localparam int Q120_MUL    = 34953;
   localparam int Q150_MUL    = 27963;
   localparam int BREATHE_MUL = 100665;
   localparam int PULSE_MUL   = 3277;

endpackage

### src/lrpg_color.sv
// ----------------------------------------------------------------------------
// LED ring pattern color lookup
// Combinational RGB levels of one pattern at a given elapsed time.
// ----------------------------------------------------------------------------
module lrpg_color (
   input  lrpg_pkg::pattern_type pattern,
   input  lrpg_pkg::ms_type      ms,
   output lrpg_pkg::level_type   red,
   output lrpg_pkg::level_type   green,
   output lrpg_pkg::level_type   blue
);
   import lrpg_pkg::*;

   logic [11:0] phase4;
   logic [10:0] up4;
   logic [10:0] phase2;
   logic [9:0]  up2;
   logic [9:0]  phase1;
   logic [27:0] breathe_prod;
   logic [21:0] pulse_prod;
   logic [28:0] prod120;
   logic [28:0] prod150;
   level_type   breathe_level;
   level_type   pulse_level;

   // Fold time into the 4000, 2000 and 1000 ms phases
   always_comb begin
      if (ms >= 14'd8000) begin
         phase4 = 12'(ms - 14'd8000);
      end else if (ms >= 14'd4000) begin
         phase4 = 12'(ms - 14'd4000);
      end else begin
         phase4 = ms[11:0];
      end
      up4    = (phase4 < 12'd2000) ? phase4[10:0] : 11'(12'd4000 - phase4);
      phase2 = (phase4 >= 12'd2000) ? 11'(phase4 - 12'd2000) : phase4[10:0];
      up2    = (phase2 < 11'd1000) ? phase2[9:0] : 10'(11'd2000 - phase2);
      phase1 = (phase2 >= 11'd1000) ? 10'(phase2 - 11'd1000) : phase2[9:0];
   end

   // Triangle levels and flash periods by reciprocal multiply
   assign breathe_prod  = 28'(up4) * 28'(BREATHE_MUL);
   assign pulse_prod    = 22'(up2) * 22'(PULSE_MUL);
   assign prod120       = 29'(ms) * 29'(Q120_MUL);
   assign prod150       = 29'(ms) * 29'(Q150_MUL);
   assign breathe_level = 8'd2 + {4'd0, breathe_prod[27:24]};
   assign pulse_level   = 8'd10 + {2'd0, pulse_prod[21:16]};

   // Select the color of the pattern
   always_comb begin
      red   = 8'd0;
      green = 8'd0;
      blue  = 8'd0;
      unique case (pattern)
         PAT_WHITE: begin
            red   = 8'd12;
            green = 8'd12;
            blue  = 8'd12;
         end
         PAT_BREATHE: begin
            red   = breathe_level;
            green = breathe_level;
            blue  = breathe_level;
         end
         PAT_AMBER_SLOW: begin
            if (phase1 < 10'd650) begin
               red   = 8'd80;
               green = 8'd40;
            end
         end
         PAT_AMBER_RAPID: begin
            if (prod120[22]) begin
               red   = 8'd80;
               green = 8'd40;
            end
         end
         PAT_GREEN: begin
            green = 8'd90;
         end
         PAT_BLUE_PULSE: begin
            blue = pulse_level;
         end
         PAT_RED_TRIPLE: begin
            if (!prod150[22]) begin
               red = 8'd90;
            end
         end
         PAT_SOLID_RED: begin
            red = 8'd64;
         end
         default: begin
            // off and undefined codes stay dark
         end
      endcase
   end

endmodule

### src/led_ring_pattern_generator_unit.sv
// ----------------------------------------------------------------------------
// LED ring pattern generator
// Renders animated RGB patterns one tick at a time, with timed pattern plays.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                                 | tuser
//  req_     | in        | [3:0] pattern, [7:4] next_pattern     | [1:0] op
//  rsp_     | out       | [7:0] red, [15:8] green, [23:16] blue | none
//
//  One item per cycle while results are taken; a tick passes through the input
//  register, then the color logic, into the result register, and its color is
//  valid on rsp_ once the result register holds it.
//  Set and play items update state and give no result.
//  Reset clears the pattern, the elapsed time and any pending switch.
//  A stalled result holds the input register only when it holds a tick.
// ----------------------------------------------------------------------------
module led_ring_pattern_generator_unit #(
   parameter int TICK_MILLISECONDS = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] pattern, [7:4] next_pattern
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [7:0] red, [15:8] green, [23:16] blue
);
   import lrpg_pkg::*;

   // Tick counts of each play, rounded up and clamped to the counter
   localparam int TickStep  = TICK_MILLISECONDS % TIME_WRAP;
   localparam int RawSlow   = (PLAY_MS_AMBER_SLOW + TICK_MILLISECONDS - 1) / TICK_MILLISECONDS;
   localparam int RawGreen  = (PLAY_MS_GREEN + TICK_MILLISECONDS - 1) / TICK_MILLISECONDS;
   localparam int RawTriple = (PLAY_MS_RED_TRIPLE + TICK_MILLISECONDS - 1) / TICK_MILLISECONDS;
   localparam int RawDef    = (PLAY_MS_DEFAULT + TICK_MILLISECONDS - 1) / TICK_MILLISECONDS;
   localparam int TicksSlow   = (RawSlow > COUNT_MAX) ? COUNT_MAX : ((RawSlow < 1) ? 1 : RawSlow);
   localparam int TicksGreen  = (RawGreen > COUNT_MAX) ? COUNT_MAX :
                                ((RawGreen < 1) ? 1 : RawGreen);
   localparam int TicksTriple = (RawTriple > COUNT_MAX) ? COUNT_MAX :
                                ((RawTriple < 1) ? 1 : RawTriple);
   localparam int TicksDef    = (RawDef > COUNT_MAX) ? COUNT_MAX : ((RawDef < 1) ? 1 : RawDef);

   function automatic ticks_type play_ticks(input pattern_type pat);
      ticks_type n;
      if (pat == PAT_AMBER_SLOW) begin
         n = 7'(TicksSlow);
      end else if (pat == PAT_GREEN) begin
         n = 7'(TicksGreen);
      end else if (pat == PAT_RED_TRIPLE) begin
         n = 7'(TicksTriple);
      end else begin
         n = 7'(TicksDef);
      end
      return n;
   endfunction

   logic        in_valid_ff;
   op_type      in_op_ff;
   pattern_type in_pattern_ff;
   pattern_type in_next_ff;
   logic        in_move;

   pattern_type current_ff, current_in;
   ms_type      ms_ff, ms_in;
   ticks_type   ticks_ff, ticks_in;
   pattern_type pending_ff, pending_in;
   logic [14:0] ms_sum;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff;
   level_type   red;
   level_type   green;
   level_type   blue;

   // Advance the held item unless it is a tick blocked by a full result
   assign in_move    = in_valid_ff &&
                       ((in_op_ff != OP_TICK) || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || in_move;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_op_ff      <= op_type'(req_tuser);
         in_pattern_ff <= req_tdata[3:0];
         in_next_ff    <= req_tdata[7:4];
      end
   end

   lrpg_color u_color (
      .pattern (current_ff),
      .ms      (ms_ff),
      .red     (red),
      .green   (green),
      .blue    (blue)
   );

   // Apply the held item to the pattern state
   always_comb begin
      current_in   = current_ff;
      ms_in        = ms_ff;
      ticks_in     = ticks_ff;
      pending_in   = pending_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ms_sum       = {1'b0, ms_ff} + 15'(TickStep);
      if (in_move) begin
         unique case (in_op_ff)
            OP_TICK: begin
               rsp_valid_in = 1'b1;
               ms_in = (ms_sum >= 15'(TIME_WRAP)) ? 14'(ms_sum - 15'(TIME_WRAP))
                                                  : ms_sum[13:0];
               if (ticks_ff != 7'd0) begin
                  ticks_in = ticks_ff - 7'd1;
                  if (ticks_ff == 7'd1) begin
                     current_in = pending_ff;
                     ms_in      = 14'd0;
                  end
               end
            end
            OP_SET: begin
               current_in = in_pattern_ff;
               ms_in      = 14'd0;
            end
            OP_PLAY: begin
               current_in = in_pattern_ff;
               ms_in      = 14'd0;
               pending_in = in_next_ff;
               ticks_in   = play_ticks(in_pattern_ff);
            end
            default: begin
               // reserved op: drop the item
            end
         endcase
      end
   end

   // State and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff   <= PAT_OFF;
         ms_ff        <= 14'd0;
         ticks_ff     <= 7'd0;
         pending_ff   <= PAT_OFF;
         rsp_valid_ff <= 1'b0;
      end else begin
         current_ff   <= current_in;
         ms_ff        <= ms_in;
         ticks_ff     <= ticks_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (in_move && (in_op_ff == OP_TICK)) begin
         rsp_data_ff <= {blue, green, red};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // Elapsed time stays inside the common period
   a_ms_range: assert property (@(posedge clock) disable iff (reset)
      ms_ff < 14'(TIME_WRAP))
      else $error("elapsed time out of range");

   // The last countdown tick switches to the pending pattern at time zero
   a_switch: assert property (@(posedge clock) disable iff (reset)
      (in_move && (in_op_ff == OP_TICK) && (ticks_ff == 7'd1)) |=>
      ((current_ff == $past(pending_ff)) && (ms_ff == 14'd0) && (ticks_ff == 7'd0)))
      else $error("pending switch not taken");

   // A set keeps any pending switch
   a_set_keeps: assert property (@(posedge clock) disable iff (reset)
      (in_move && (in_op_ff == OP_SET)) |=>
      ((ticks_ff == $past(ticks_ff)) && (pending_ff == $past(pending_ff))))
      else $error("set disturbed pending switch");
`endif

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// LED ring pattern generator testbench
// Drives tick, set and play items into the pattern generator, predicts each
// tick's color from its own model of pattern, elapsed time and play countdown,
// and checks every returned color field by field, with random stalls on both
// channels.
// ----------------------------------------------------------------------------
module tb;
   import lrpg_pkg::*;

   localparam int TICK_MS = 25;

   // Item code the block ignores
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // One request item plus a flag that holds it until all colors are back
   typedef struct {
      logic [1:0]  op;
      pattern_type pattern;
      pattern_type next_pattern;
      bit          wait_idle;
   } led_cmd_type;

   // Same layout as rsp_tdata: red in the lowest byte
   typedef struct packed {
      level_type blue;
      level_type green;
      level_type red;
   } rgb_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [3:0] pattern, [7:4] next_pattern
   logic [1:0]  req_tuser = '0;   // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [7:0] red, [15:8] green, [23:16] blue

   led_cmd_type cmd_queue[$];
   rgb_type     color_queue[$];
   led_cmd_type drive_cmd;

   // Model state
   pattern_type model_pattern = PAT_OFF;
   pattern_type model_pending = PAT_OFF;
   int          model_ms = 0;
   int          model_ticks_left = 0;

   // Handshake bookkeeping
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   int   send_gap = 0;
   int   send_quiet = 0;
   int   recv_wait = 0;
   int   recv_quiet = 0;

   // Counters
   int error_count = 0;
   int n_queued = 0;
   int n_accepted = 0;
   int n_checked = 0;
   int n_ticks = 0;
   int n_sets = 0;
   int n_plays = 0;
   int n_switches = 0;
   int n_ignored = 0;
   int n_wraps = 0;

   led_ring_pattern_generator_unit #(
      .TICK_MILLISECONDS(TICK_MS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Idle cycles before the next item; now and then a stretch with none
   function automatic int draw_wait(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) begin
         quiet_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 5);
   endfunction

   // Mostly defined patterns, sometimes an undefined code
   function automatic pattern_type random_pattern();
      if ($urandom_range(0, 7) == 0)
         return pattern_type'($urandom_range(9, 15));
      return pattern_type'($urandom_range(0, 8));
   endfunction

   // Color of a pattern at a given elapsed time
   function automatic rgb_type pattern_color(pattern_type pat, int ms);
      int      phase;
      int      rise;
      rgb_type c;
      c = '0;
      case (pat)
         PAT_WHITE: begin
            c.red = 8'd12; c.green = 8'd12; c.blue = 8'd12;
         end
         PAT_BREATHE: begin
            phase = ms % 4000;
            rise = (phase < 2000) ? phase : 4000 - phase;
            c.red = level_type'(2 + rise * 12 / 2000);
            c.green = c.red;
            c.blue = c.red;
         end
         PAT_AMBER_SLOW: begin
            if (ms % 1000 < 650) begin
               c.red = 8'd80; c.green = 8'd40;
            end
         end
         PAT_AMBER_RAPID: begin
            if ((ms / 120) % 2 == 1) begin
               c.red = 8'd80; c.green = 8'd40;
            end
         end
         PAT_GREEN: c.green = 8'd90;
         PAT_BLUE_PULSE: begin
            phase = ms % 2000;
            rise = (phase < 1000) ? phase : 2000 - phase;
            c.blue = level_type'(10 + rise * 50 / 1000);
         end
         PAT_RED_TRIPLE: begin
            if ((ms / 150) % 2 == 0) c.red = 8'd90;
         end
         PAT_SOLID_RED: c.red = 8'd64;
         default: c = '0;
      endcase
      return c;
   endfunction

   // Ticks a play lasts: duration rounded up to whole ticks, saturated
   function automatic int play_tick_count(pattern_type pat);
      int dur;
      int tick;
      int n;
      tick = (TICK_MS == 0) ? 1 : TICK_MS;
      case (pat)
         PAT_AMBER_SLOW: dur = PLAY_MS_AMBER_SLOW;
         PAT_GREEN:      dur = PLAY_MS_GREEN;
         PAT_RED_TRIPLE: dur = PLAY_MS_RED_TRIPLE;
         default:        dur = PLAY_MS_DEFAULT;
      endcase
      n = (dur + tick - 1) / tick;
      if (n == 0) n = 1;
      if (n > COUNT_MAX) n = COUNT_MAX;
      return n;
   endfunction

   // Advance the model by one accepted item; queue the color of a tick
   task automatic apply_command(logic [1:0] op, pattern_type pat, pattern_type nxt);
      case (op)
         OP_SET: begin
            model_pattern = pat;
            model_ms = 0;
            n_sets++;
         end
         OP_PLAY: begin
            model_pattern = pat;
            model_ms = 0;
            model_pending = nxt;
            model_ticks_left = play_tick_count(pat);
            n_plays++;
         end
         OP_TICK: begin
            color_queue.push_back(pattern_color(model_pattern, model_ms));
            n_ticks++;
            if (model_ms + TICK_MS % TIME_WRAP >= TIME_WRAP) n_wraps++;
            model_ms = (model_ms + TICK_MS % TIME_WRAP) % TIME_WRAP;
            if (model_ticks_left != 0) begin
               model_ticks_left--;
               if (model_ticks_left == 0) begin
                  model_pattern = model_pending;
                  model_ms = 0;
                  n_switches++;
               end
            end
         end
         default: n_ignored++;
      endcase
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH at color %0d: %s got %0d, expected %0d",
               n_checked, what, got, want);
      error_count++;
   endtask

   // Compare one returned color with the oldest expected one
   task automatic check_color(rgb_type got);
      rgb_type want;
      if (color_queue.size() == 0) begin
         report_mismatch("color with none expected, data", got, 0);
      end else begin
         want = color_queue.pop_front();
         if (got.red !== want.red) report_mismatch("red", got.red, want.red);
         if (got.green !== want.green) report_mismatch("green", got.green, want.green);
         if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
      end
      n_checked++;
   endtask

   task automatic queue_cmd(logic [1:0] op, pattern_type pat, pattern_type nxt,
                            bit wait_idle);
      led_cmd_type c;
      c.op = op;
      c.pattern = pat;
      c.next_pattern = nxt;
      c.wait_idle = wait_idle;
      cmd_queue.push_back(c);
      n_queued++;
   endtask

   // Drive the request channel from the item queue
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (cmd_queue.size() > 0 &&
                      !(cmd_queue[0].wait_idle && color_queue.size() > 0)) begin
            drive_cmd = cmd_queue.pop_front();
            req_tuser <= drive_cmd.op;
            req_tdata <= {drive_cmd.next_pattern, drive_cmd.pattern};
            req_tvalid <= 1'b1;
            send_gap = draw_wait(send_quiet);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Stall the result channel for a random count after each result
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken) recv_wait = draw_wait(recv_quiet);
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         rsp_taken <= rsp_tvalid && rsp_tready;
         if (req_tvalid && req_tready) begin
            apply_command(req_tuser, req_tdata[3:0], req_tdata[7:4]);
            n_accepted++;
         end
         if (rsp_tvalid && rsp_tready) check_color(rgb_type'(rsp_tdata));
      end
   end

   // Stimulus, then wait for the last color and report
   initial begin
      int          i;
      int          k;
      int          run;
      int          r;
      int          sessions;
      int          random_items;
      pattern_type p;

      // Color right after reset, then every pattern once
      queue_cmd(OP_TICK, PAT_OFF, PAT_OFF, 1'b0);
      for (i = 1; i <= 8; i++) begin
         queue_cmd(OP_SET, pattern_type'(i), PAT_OFF, 1'b0);
         queue_cmd(OP_TICK, PAT_OFF, PAT_OFF, 1'b0);
      end
      // Undefined pattern code renders as off
      queue_cmd(OP_SET, 4'hF, 4'hF, 1'b0);
      queue_cmd(OP_TICK, 4'hF, 4'hF, 1'b0);
      // Undefined op with every data bit set
      queue_cmd(OP_UNUSED, 4'hF, 4'hF, 1'b0);
      // Play, set during the pending switch, then a play that replaces it
      queue_cmd(OP_PLAY, PAT_GREEN, 4'hF, 1'b0);
      queue_cmd(OP_TICK, PAT_OFF, PAT_OFF, 1'b0);
      queue_cmd(OP_SET, PAT_BREATHE, PAT_OFF, 1'b0);
      queue_cmd(OP_TICK, PAT_OFF, PAT_OFF, 1'b0);
      queue_cmd(OP_PLAY, PAT_RED_TRIPLE, PAT_OFF, 1'b0);
      queue_cmd(OP_TICK, PAT_OFF, PAT_OFF, 1'b0);

      // Sessions: a set or play followed by a run of ticks with rare
      // interruptions; one run is much longer than the others
      sessions = 0;
      random_items = 0;
      while (random_items < 1000) begin
         p = random_pattern();
         if ($urandom_range(0, 9) < 4)
            queue_cmd(OP_SET, p, random_pattern(), sessions % 8 == 0);
         else
            queue_cmd(OP_PLAY, p, random_pattern(), sessions % 8 == 0);
         random_items++;
         run = (sessions == 1) ? 500 : $urandom_range(1, 140);
         for (k = 0; k < run; k++) begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
               queue_cmd(OP_UNUSED, pattern_type'($urandom), pattern_type'($urandom),
                         1'b0);
            end else if (r < 4) begin
               queue_cmd(OP_SET, random_pattern(), random_pattern(), 1'b0);
               random_items++;
            end else if (r < 5) begin
               queue_cmd(OP_PLAY, random_pattern(), random_pattern(), 1'b0);
               random_items++;
            end else begin
               queue_cmd(OP_TICK, pattern_type'($urandom), pattern_type'($urandom),
                         1'b0);
               random_items++;
            end
         end
         sessions++;
      end

      // Release reset
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every item to go in and every color to come back
      while (n_accepted < n_queued || color_queue.size() > 0) @(negedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d ticks, %0d sets, %0d plays and %0d ignored items",
               n_ticks, n_sets, n_plays, n_ignored);
      $display("Checked %0d colors across %0d timed switches and %0d time wraps",
               n_checked, n_switches, n_wraps);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #400000;
      $display("Timeout: %0d of %0d items accepted, %0d colors outstanding",
               n_accepted, n_queued, color_queue.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
